FILE: design/clhm_pkg.sv
// Shared types and constants for the CPU load history meter.
// No dependencies; imported by every module of the block.
`default_nettype none

package clhm_pkg;

    localparam int FS_W   = 32;
    localparam int LOAD_W = 8;
    localparam int TICK_W = 7;
    localparam int DIV_W  = FS_W + LOAD_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int ADDR_W = 3;

    localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(64);
    localparam logic [LOAD_W-1:0] LOAD_FULL  = LOAD_W'(255);
    localparam logic [FS_W-1:0]   FS_RESET   = FS_W'(1049937);

    localparam int SHORT_SLOTS_DEF = 16;
    localparam int LONG_SLOTS_DEF  = 64;

    typedef enum logic {
        REG_FULL_SCALE = 1'b0,
        REG_CALIBRATE  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LSTART,
        ST_LDIV,
        ST_SLOT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic load_start;
        logic load_fix;
        logic load_quot;
        logic slot_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic tick_nz;
        logic special;
        logic div_busy;
        logic out_free;
        logic last;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/clhm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on clhm_pkg.
`default_nettype none

module clhm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [clhm_pkg::DIV_W-1:0]  dividend,
    input  wire logic [clhm_pkg::FS_W-1:0]   divisor,
    input  wire logic [clhm_pkg::CNT_W-1:0]  count,
    output      logic                       busy,
    output      logic [clhm_pkg::LOAD_W-1:0] quotient
);
    import clhm_pkg::*;

    logic [FS_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [FS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [FS_W:0]    trial;
    logic [FS_W:0]    diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[FS_W-1:0] : trial[FS_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[LOAD_W-1:0];

endmodule

`default_nettype wire

FILE: design/clhm_dp.sv
// Datapath: input latches, load division, ring mean by reciprocal multiply, ring counters,
// running sum, calibration maximum and output register. Depends on clhm_pkg and clhm_div.
`default_nettype none

module clhm_dp #(
    parameter int SHORT_SLOTS = clhm_pkg::SHORT_SLOTS_DEF,
    parameter int LONG_SLOTS  = clhm_pkg::LONG_SLOTS_DEF,
    localparam int SP_W = $clog2(SHORT_SLOTS),
    localparam int LP_W = $clog2(LONG_SLOTS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [clhm_pkg::FS_W-1:0]   full_scale_count,
    input  wire logic                        calibration_enable,
    input  wire logic [clhm_pkg::FS_W-1:0]   idle_count,
    input  wire logic [clhm_pkg::TICK_W-1:0] tick_count,
    input  wire clhm_pkg::cmd_t              cmd,
    output      clhm_pkg::sts_t              sts,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic [clhm_pkg::LOAD_W-1:0] slot_load,
    output      logic [SP_W-1:0]             short_slot,
    output      logic                        long_written,
    output      logic [clhm_pkg::LOAD_W-1:0] long_average,
    output      logic [LP_W-1:0]             long_slot,
    output      logic [clhm_pkg::FS_W-1:0]   max_idle_seen,
    output      logic                        last_of_run
);
    import clhm_pkg::*;

    localparam int SUM_W  = LOAD_W + $clog2(SHORT_SLOTS);
    localparam int MSH    = SUM_W + $clog2(SHORT_SLOTS);
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    // ceil(2^MSH / SHORT_SLOTS): exact floor division for any sum below 2^SUM_W
    localparam logic [MUL_W-1:0] MEAN_MUL =
        MUL_W'(((64'd1 << MSH) + 64'(SHORT_SLOTS - 1)) / 64'(SHORT_SLOTS));

    logic [FS_W-1:0]   idle_reg;
    logic [TICK_W-1:0] rem_reg;
    logic [FS_W-1:0]   max_reg;
    logic [FS_W-1:0]   diff_reg;
    logic              special_reg;
    logic [LOAD_W-1:0] fix_reg;
    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] mean_reg;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SP_W-1:0]   spos_reg;
    logic [LP_W-1:0]   lpos_reg;
    logic              ovalid_reg;

    logic [LOAD_W-1:0] o_load_reg, o_avg_reg;
    logic [SP_W-1:0]   o_spos_reg;
    logic [LP_W-1:0]   o_lpos_reg;
    logic              o_wrote_reg, o_last_reg;
    logic [FS_W-1:0]   o_max_reg;

    logic [TICK_W-1:0] ticks_sat;
    logic              wrap;
    logic              lwrap;
    logic [PROD_W-1:0] mean_prod;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic              div_busy;
    logic [LOAD_W-1:0] div_quot;

    assign ticks_sat = (tick_count > TICK_LIMIT) ? TICK_LIMIT : tick_count;
    assign wrap      = spos_reg == SP_W'(SHORT_SLOTS - 1);
    assign lwrap     = lpos_reg == LP_W'(LONG_SLOTS - 1);
    assign acc_next  = acc_reg + SUM_W'(load_reg);
    assign mean_prod = PROD_W'(acc_next) * PROD_W'(MEAN_MUL);

    assign div_start    = cmd.load_start;
    assign div_dividend = {diff_reg, {LOAD_W{1'b0}}} - {{LOAD_W{1'b0}}, diff_reg};

    clhm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (full_scale_count),
        .count    (CNT_W'(DIV_W)),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= '0;
            acc_reg    <= '0;
            spos_reg   <= '0;
            lpos_reg   <= '0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                rem_reg <= ticks_sat;
                if (calibration_enable && (idle_count > max_reg))
                    max_reg <= idle_count;
            end
            if (cmd.slot_step)
                acc_reg <= wrap ? '0 : acc_next;
            if (cmd.emit)
            begin
                rem_reg  <= rem_reg - TICK_W'(1);
                spos_reg <= wrap ? '0 : spos_reg + SP_W'(1);
                if (wrap)
                    lpos_reg <= lwrap ? '0 : lpos_reg + LP_W'(1);
            end
            if (cmd.emit)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            idle_reg <= idle_count;
        if (cmd.prep)
        begin
            diff_reg    <= full_scale_count - idle_reg;
            special_reg <= (full_scale_count == '0) || (idle_reg > full_scale_count);
            fix_reg     <= ((full_scale_count == '0) && (idle_reg == '0)) ? LOAD_FULL : '0;
        end
        if (cmd.load_fix)
            load_reg <= fix_reg;
        else if (cmd.load_quot)
            load_reg <= div_quot;
        else if (cmd.emit)
            load_reg <= LOAD_FULL;
        if (cmd.slot_step)
            mean_reg <= mean_prod[MSH +: LOAD_W];
        if (cmd.emit)
        begin
            o_load_reg  <= load_reg;
            o_spos_reg  <= spos_reg;
            o_wrote_reg <= wrap;
            o_avg_reg   <= wrap ? mean_reg : '0;
            o_lpos_reg  <= wrap ? lpos_reg : '0;
            o_max_reg   <= max_reg;
            o_last_reg  <= rem_reg == TICK_W'(1);
        end
    end

    always_comb
    begin
        sts.tick_nz  = tick_count != '0;
        sts.special  = special_reg;
        sts.div_busy = div_busy;
        sts.out_free = !ovalid_reg || !out_stall;
        sts.last     = rem_reg == TICK_W'(1);
    end

    assign out_valid     = ovalid_reg;
    assign slot_load     = o_load_reg;
    assign short_slot    = o_spos_reg;
    assign long_written  = o_wrote_reg;
    assign long_average  = o_avg_reg;
    assign long_slot     = o_lpos_reg;
    assign max_idle_seen = o_max_reg;
    assign last_of_run   = o_last_reg;

endmodule

`default_nettype wire

FILE: design/clhm_ctrl.sv
// Controller state machine sequencing load division, slot steps and results.
// Depends on clhm_pkg.
`default_nettype none

module clhm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output      logic           in_stall,
    input  wire clhm_pkg::sts_t sts,
    output      clhm_pkg::cmd_t cmd
);
    import clhm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.tick_nz)
                    state_next = ST_PREP;
            end
            ST_PREP:   state_next = ST_LSTART;
            ST_LSTART: state_next = sts.special ? ST_SLOT : ST_LDIV;
            ST_LDIV:
            begin
                if (!sts.div_busy)
                    state_next = ST_SLOT;
            end
            ST_SLOT:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (sts.out_free)
                    state_next = sts.last ? ST_IDLE : ST_SLOT;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid && sts.tick_nz;
            end
            ST_PREP:   cmd.prep = 1'b1;
            ST_LSTART:
            begin
                cmd.load_fix   = sts.special;
                cmd.load_start = !sts.special;
            end
            ST_LDIV:   cmd.load_quot = !sts.div_busy;
            ST_SLOT:   cmd.slot_step = 1'b1;
            ST_EMIT:   cmd.emit = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/cpu_load_history_meter_unit.sv
// CPU load history meter, one update in flight: after the transfer an update runs PREP,
// LSTART, the 40-step load divide (LDIV), then SLOT and EMIT for each of T slots, T the
// saturated tick count; an output stall holds EMIT. Without the divide (zero full scale or
// idle above it) LSTART goes straight to the first SLOT. The next input is taken in IDLE.
// Reset (rst_n low, asynchronous) clears positions, running sum, calibration maximum,
// and loads full_scale_count = 1049937, calibration_enable = 0. No clearing pass.
`default_nettype none

module cpu_load_history_meter_unit #(
    parameter int SHORT_SLOTS = clhm_pkg::SHORT_SLOTS_DEF,
    parameter int LONG_SLOTS  = clhm_pkg::LONG_SLOTS_DEF,
    localparam int SP_W = $clog2(SHORT_SLOTS),
    localparam int LP_W = $clog2(LONG_SLOTS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [clhm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic [clhm_pkg::FS_W-1:0]   idle_count,
    input  wire logic [clhm_pkg::TICK_W-1:0] tick_count,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic [clhm_pkg::LOAD_W-1:0] slot_load,
    output      logic [SP_W-1:0]             short_slot,
    output      logic                        long_written,
    output      logic [clhm_pkg::LOAD_W-1:0] long_average,
    output      logic [LP_W-1:0]             long_slot,
    output      logic [clhm_pkg::FS_W-1:0]   max_idle_seen,
    output      logic                        last_of_run
);
    import clhm_pkg::*;

    logic [FS_W-1:0] fs_reg;
    logic            cal_reg;
    logic            wr_en;
    reg_idx_t        idx;
    cmd_t            cmd;
    sts_t            sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg  <= FS_RESET;
            cal_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FULL_SCALE: fs_reg  <= pwdata;
                REG_CALIBRATE:  cal_reg <= pwdata[0];
                default:        cal_reg <= cal_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FULL_SCALE: prdata = fs_reg;
            REG_CALIBRATE:  prdata = {31'b0, cal_reg};
            default:        prdata = '0;
        endcase
    end

    clhm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    clhm_dp #(
        .SHORT_SLOTS (SHORT_SLOTS),
        .LONG_SLOTS  (LONG_SLOTS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .full_scale_count   (fs_reg),
        .calibration_enable (cal_reg),
        .idle_count         (idle_count),
        .tick_count         (tick_count),
        .cmd                (cmd),
        .sts                (sts),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .slot_load          (slot_load),
        .short_slot         (short_slot),
        .long_written       (long_written),
        .long_average       (long_average),
        .long_slot          (long_slot),
        .max_idle_seen      (max_idle_seen),
        .last_of_run        (last_of_run)
    );

endmodule

`default_nettype wire

FILE: dv/clhm_board_pkg.sv
// Scoreboard for the CPU load history meter: result record and a class that
// predicts the slot results of each update. Depends on clhm_pkg.
`timescale 1ns / 100ps

package clhm_board_pkg;

    import clhm_pkg::*;

    localparam int RING_N = SHORT_SLOTS_DEF;
    localparam int HIST_N = LONG_SLOTS_DEF;

    typedef struct packed {
        logic [LOAD_W-1:0] slot_load;
        logic [3:0]        short_slot;
        logic              long_written;
        logic [LOAD_W-1:0] long_average;
        logic [5:0]        long_slot;
        logic [FS_W-1:0]   max_idle;
        logic              last;
    } slot_result_t;

    class load_history_board;
        logic [FS_W-1:0]   full_scale;
        logic              calibrate;
        logic [LOAD_W-1:0] ring [RING_N];
        int unsigned       short_pos;
        int unsigned       long_pos;
        logic [FS_W-1:0]   idle_max;
        slot_result_t      pending_slots[$];
        int unsigned       failures;
        int unsigned       updates;
        int unsigned       slots_seen;
        int unsigned       wraps;

        function new();
            full_scale = FS_RESET;
            calibrate  = 1'b0;
            foreach (ring[i]) ring[i] = '0;
            short_pos  = 0;
            long_pos   = 0;
            idle_max   = '0;
            failures   = 0;
            updates    = 0;
            slots_seen = 0;
            wraps      = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_FULL_SCALE: full_scale = value;
                REG_CALIBRATE:  calibrate  = value[0];
                default: ;
            endcase
        endfunction

        function logic [LOAD_W-1:0] load_for(logic [FS_W-1:0] idle);
            logic [63:0] span;
            if (full_scale == '0)
                return (idle == '0) ? LOAD_FULL : '0;
            if (idle > full_scale)
                return '0;
            span = 64'(full_scale - idle) * 64'd255;
            return LOAD_W'(span / 64'(full_scale));
        endfunction

        function void note_update(logic [FS_W-1:0] idle, logic [TICK_W-1:0] ticks);
            int unsigned       n;
            slot_result_t      r;
            logic [11:0]       sum;
            logic [LOAD_W-1:0] load;
            if (ticks == '0)
                return;
            n = (ticks > TICK_LIMIT) ? TICK_LIMIT : ticks;
            updates++;
            if (calibrate && idle > idle_max)
                idle_max = idle;
            for (int k = 0; k < n; k++)
            begin
                load = (k == 0) ? load_for(idle) : LOAD_FULL;
                ring[short_pos] = load;
                r = '0;
                r.slot_load  = load;
                r.short_slot = short_pos[3:0];
                r.max_idle   = idle_max;
                r.last       = (k == n - 1);
                if (short_pos == RING_N - 1)
                begin
                    sum = '0;
                    foreach (ring[i]) sum += ring[i];
                    r.long_written = 1'b1;
                    r.long_average = LOAD_W'(sum / RING_N);
                    r.long_slot    = long_pos[5:0];
                    long_pos       = (long_pos + 1) % HIST_N;
                    short_pos      = 0;
                end
                else
                begin
                    short_pos++;
                end
                pending_slots.push_back(r);
            end
        endfunction

        function void check_slot(slot_result_t got);
            slot_result_t want;
            if (pending_slots.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected slot result: load=%0d slot=%0d", got.slot_load,
                             got.short_slot);
                return;
            end
            want = pending_slots.pop_front();
            slots_seen++;
            if (want.long_written)
                wraps++;
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("slot mismatch: exp load=%0d slot=%0d lw=%0d avg=%0d lslot=%0d max=%h last=%0d\n              got load=%0d slot=%0d lw=%0d avg=%0d lslot=%0d max=%h last=%0d",
                             want.slot_load, want.short_slot, want.long_written,
                             want.long_average, want.long_slot, want.max_idle, want.last,
                             got.slot_load, got.short_slot, got.long_written,
                             got.long_average, got.long_slot, got.max_idle, got.last);
            end
        endfunction
    endclass

endpackage

FILE: dv/tb_cpu_load_history_meter_unit.sv
// Testbench top for cpu_load_history_meter_unit: APB register setup, randomized
// update traffic with stalls, slot results checked against clhm_board_pkg.
// Depends on clhm_pkg, clhm_board_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_cpu_load_history_meter_unit;

    import clhm_pkg::*;
    import clhm_board_pkg::*;

    localparam int QUIET_LIMIT = 10000;
    localparam int SETTLE      = 300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FS_W-1:0]     idle_count = '0;
    logic [TICK_W-1:0]   tick_count = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LOAD_W-1:0]   slot_load;
    logic [3:0]          short_slot;
    logic                long_written;
    logic [LOAD_W-1:0]   long_average;
    logic [5:0]          long_slot;
    logic [FS_W-1:0]     max_idle_seen;
    logic                last_of_run;

    load_history_board board = new();
    bit          idling_on = 1'b1;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int unsigned settings_used = 1;

    cpu_load_history_meter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .idle_count    (idle_count),
        .tick_count    (tick_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_load     (slot_load),
        .short_slot    (short_slot),
        .long_written  (long_written),
        .long_average  (long_average),
        .long_slot     (long_slot),
        .max_idle_seen (max_idle_seen),
        .last_of_run   (last_of_run)
    );

    always #2 clk = ~clk;

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic send_update(input logic [FS_W-1:0] idle_val,
                               input logic [TICK_W-1:0] ticks_val);
        while (idling_on && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        idle_count <= idle_val;
        tick_count <= ticks_val;
        do @(posedge clk); while (in_stall);
        board.note_update(idle_val, ticks_val);
    endtask

    // drop in_valid, wait until every predicted slot result is checked, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_slots.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [FS_W-1:0] fs, input logic cal);
        wait_drained();
        apb_write(REG_FULL_SCALE, fs);
        apb_write(REG_CALIBRATE, {31'd0, cal});
        settings_used++;
    endtask

    function automatic logic [FS_W-1:0] pick_idle(input logic [FS_W-1:0] fs);
        logic [63:0] span;
        span = {32'd0, fs} + 64'd1;
        case ($urandom_range(7))
            0: return '0;
            1: return fs;
            2: return fs + 32'd1;
            3: return 32'hFFFF_FFFF;
            4: return fs - 32'($urandom_range(3));
            5: return $urandom;
            default: return 32'({$urandom, $urandom} % span);
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_ticks();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 65)
            return TICK_W'($urandom_range(8, 1));
        else if (r < 90)
            return TICK_W'($urandom_range(64, 9));
        return TICK_W'($urandom_range(127, 65));
    endfunction

    task automatic run_phase(input logic [FS_W-1:0] fs, input logic cal, input int n,
                             input bit quiet);
        reconfigure(fs, cal);
        idling_on = !quiet;
        for (int i = 0; i < n; i++)
        begin
            if (quiet && i == 3)
                hold_left = 400;
            send_update(pick_idle(fs), pick_ticks());
        end
        idling_on = 1'b1;
    endtask

    // result side: check, then choose next stall
    initial
    begin
        slot_result_t got;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.slot_load    = slot_load;
                got.short_slot   = short_slot;
                got.long_written = long_written;
                got.long_average = long_average;
                got.long_slot    = long_slot;
                got.max_idle     = max_idle_seen;
                got.last         = last_of_run;
                board.check_slot(got);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= idling_on && ($urandom_range(99) < 35);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_cpu_load_history_meter_unit failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned fails;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: load edges, tick saturation, tick-free update
        send_update(32'd0, 7'd1);
        send_update(FS_RESET, 7'd1);
        send_update(FS_RESET + 32'd1, 7'd1);
        send_update(32'hFFFF_FFFF, 7'd1);
        send_update(FS_RESET / 2, 7'd3);
        send_update(32'd1234, 7'd0);
        send_update(32'd0, 7'd64);
        send_update(32'd5000, 7'd65);
        send_update(FS_RESET - 32'd1, 7'd127);

        // calibration: tick-free update must not raise the maximum
        reconfigure(32'hFFFF_FFFF, 1'b1);
        send_update(32'd1, 7'd1);
        send_update(32'h8000_0000, 7'd0);
        send_update(32'd0, 7'd2);
        send_update(32'hFFFF_FFFF, 7'd1);

        // zero full scale
        reconfigure(32'd0, 1'b1);
        send_update(32'd0, 7'd1);
        send_update(32'd1, 7'd1);
        send_update(32'hFFFF_FFFF, 7'd2);

        reconfigure(32'd1, 1'b0);
        send_update(32'd0, 7'd1);
        send_update(32'd1, 7'd1);
        send_update(32'd2, 7'd1);
        send_update(32'h5555_AAAA, 7'd16);

        run_phase(FS_RESET, 1'b0, 45, 1'b0);
        run_phase($urandom, 1'b1, 45, 1'b0);
        run_phase(32'hFFFF_FFFF, 1'b1, 45, 1'b1);
        run_phase(32'd0, 1'b0, 40, 1'b0);
        run_phase(32'd1, 1'b1, 40, 1'b0);
        run_phase(32'($urandom_range(2000, 2)), 1'b0, 45, 1'b0);

        wait_drained();
        $display("ran %0d updates giving %0d slot results and %0d long-history entries",
                 board.updates, board.slots_seen, board.wraps);
        $display("across %0d register settings, full scale 0..max, calibration on and off",
                 settings_used);
        fails = board.failures + board.pending_slots.size();
        if (fails == 0)
            $display("tb_cpu_load_history_meter_unit passed");
        else
            $display("tb_cpu_load_history_meter_unit failed");
        $finish;
    end

endmodule
